### hw/rtl/lwbfd_pkg.sv
// Shared types and constants of the LRU write-back frame directory.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package lwbfd_pkg;

  // Field widths of the item and result ports.
  localparam int OP_W      = 2;
  localparam int BLOCK_W   = 32;
  localparam int KIND_W    = 3;
  localparam int FRAME_W   = 4;
  localparam int CFG_W     = 5;
  localparam int STAMP_W   = 64;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_FETCH = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HIT        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILL       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MARKED     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MARK_MISS  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSH_WB   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FLUSH_DONE = 3'd6;

  // Reset value of the frames-in-use register.
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new item and clear the search results
    logic issue;   // read the frame at the scan index and advance it
    logic update;  // apply the decision and emit the final result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the scan index points at the last frame in use
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/lwbfd_ctrl.sv
// Controller state machine of the frame directory: idle, scan, drain, update.
// Depends on lwbfd_pkg for the command and status structs.
`default_nettype none

module lwbfd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire lwbfd_pkg::dp_status_t  status,
  output lwbfd_pkg::ctrl_cmd_t        cmd,
  output logic                        busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands follow directly from the state; load also needs start.
  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.issue  = (state == S_SCAN);
    cmd.update = (state == S_UPDATE);
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/lwbfd_datapath.sv
// Datapath of the frame directory: valid and dirty flags, tag and stamp
// memories, the scan pipeline, search registers and the result register.
// Depends on lwbfd_pkg for widths, codes and the command and status structs.
`default_nettype none

module lwbfd_datapath #(
  parameter int FRAME_COUNT = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lwbfd_pkg::CFG_W-1:0]       cfg_wr_data,
  input  wire logic [lwbfd_pkg::OP_W-1:0]        op,
  input  wire logic [lwbfd_pkg::BLOCK_W-1:0]     blk_addr,
  input  wire lwbfd_pkg::ctrl_cmd_t              cmd,
  output lwbfd_pkg::dp_status_t                  status,
  output logic                                   result_strobe,
  output logic [lwbfd_pkg::KIND_W-1:0]           kind,
  output logic [lwbfd_pkg::FRAME_W-1:0]          frame,
  output logic                                   writeback,
  output logic [lwbfd_pkg::BLOCK_W-1:0]          wb_blk_addr,
  output logic                                   last
);

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W = $clog2(FRAME_COUNT + 1);
  localparam logic [6:0] FRAME_COUNT7 = 7'(FRAME_COUNT);

  // Configuration and the effective frame count.
  logic [lwbfd_pkg::CFG_W-1:0] frames_in_use;
  logic [6:0]                  cfg_ext;
  logic [6:0]                  used7;
  logic [CNT_W-1:0]            used_frames;

  // Directory state.
  logic [FRAME_COUNT-1:0]              frame_valid;
  logic [FRAME_COUNT-1:0]              frame_dirty;
  logic [lwbfd_pkg::BLOCK_W-1:0]       tag_mem   [FRAME_COUNT];
  logic [lwbfd_pkg::STAMP_W-1:0]       stamp_mem [FRAME_COUNT];
  logic [lwbfd_pkg::STAMP_W-1:0]       stamp_counter;
  logic [lwbfd_pkg::STAMP_W-1:0]       stamp_next;

  // Captured item.
  logic [lwbfd_pkg::OP_W-1:0]          op_reg;
  logic [lwbfd_pkg::BLOCK_W-1:0]       id_reg;

  // Scan pipeline: address stage and registered read stage.
  logic [IDX_W-1:0]                    scan_idx;
  logic                                p_valid;
  logic [IDX_W-1:0]                    p_idx;
  logic [lwbfd_pkg::BLOCK_W-1:0]       rd_tag;
  logic [lwbfd_pkg::STAMP_W-1:0]       rd_stamp;

  // Search results.
  logic                                hit_found;
  logic [IDX_W-1:0]                    hit_idx;
  logic                                free_found;
  logic [IDX_W-1:0]                    free_idx;
  logic [IDX_W-1:0]                    vic_idx;
  logic [lwbfd_pkg::STAMP_W-1:0]       vic_stamp;
  logic [lwbfd_pkg::BLOCK_W-1:0]       vic_tag;
  logic [IDX_W-1:0]                    tgt_idx;

  // Result produced this cycle.
  logic                                em_valid;
  logic [lwbfd_pkg::KIND_W-1:0]        em_kind;
  logic [IDX_W-1:0]                    em_idx;
  logic                                em_wb;
  logic [lwbfd_pkg::BLOCK_W-1:0]       em_wb_id;
  logic                                em_last;
  logic                                flush_hit;
  logic                                fetch_write;

  // Clamp frames_in_use to the range 1 .. FRAME_COUNT.
  always_comb begin
    cfg_ext = {2'b00, frames_in_use};
    if (cfg_ext == 7'd0) begin
      used7 = 7'd1;
    end else if (cfg_ext > FRAME_COUNT7) begin
      used7 = FRAME_COUNT7;
    end else begin
      used7 = cfg_ext;
    end
    used_frames = CNT_W'(used7);
  end

  assign status.scan_last = (CNT_W'(scan_idx) == (used_frames - CNT_W'(1)));

  assign stamp_next  = stamp_counter + lwbfd_pkg::STAMP_W'(1);
  assign flush_hit   = p_valid && (op_reg == lwbfd_pkg::OP_FLUSH) &&
                       frame_valid[p_idx] && frame_dirty[p_idx];
  assign fetch_write = cmd.update && (op_reg == lwbfd_pkg::OP_FETCH);

  // Frame that a fetch writes: the hit, else the first free frame, else the victim.
  always_comb begin
    if (hit_found) begin
      tgt_idx = hit_idx;
    end else if (free_found) begin
      tgt_idx = free_idx;
    end else begin
      tgt_idx = vic_idx;
    end
  end

  // Result selection: flush write-backs during the scan and drain, the final result on update.
  always_comb begin
    em_valid = 1'b0;
    em_kind  = lwbfd_pkg::KIND_HIT;
    em_idx   = '0;
    em_wb    = 1'b0;
    em_wb_id = '0;
    em_last  = 1'b0;
    if (flush_hit) begin
      em_valid = 1'b1;
      em_kind  = lwbfd_pkg::KIND_FLUSH_WB;
      em_idx   = p_idx;
      em_wb    = 1'b1;
      em_wb_id = rd_tag;
    end else if (cmd.update) begin
      em_last = 1'b1;
      case (op_reg)
        lwbfd_pkg::OP_FETCH: begin
          em_valid = 1'b1;
          em_idx   = tgt_idx;
          if (hit_found) begin
            em_kind = lwbfd_pkg::KIND_HIT;
          end else if (free_found) begin
            em_kind = lwbfd_pkg::KIND_FILL;
          end else begin
            em_kind = lwbfd_pkg::KIND_EVICT;
            if (frame_dirty[vic_idx]) begin
              em_wb    = 1'b1;
              em_wb_id = vic_tag;
            end
          end
        end
        lwbfd_pkg::OP_MARK: begin
          em_valid = 1'b1;
          if (hit_found) begin
            em_kind = lwbfd_pkg::KIND_MARKED;
            em_idx  = hit_idx;
          end else begin
            em_kind = lwbfd_pkg::KIND_MARK_MISS;
          end
        end
        lwbfd_pkg::OP_FLUSH: begin
          em_valid = 1'b1;
          em_kind  = lwbfd_pkg::KIND_FLUSH_DONE;
        end
        default: begin
          em_valid = 1'b0;
        end
      endcase
    end
  end

  // Control state: configuration, flags, counter, scan and search bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lwbfd_pkg::FRAMES_IN_USE_RESET;
      frame_valid   <= '0;
      frame_dirty   <= '0;
      stamp_counter <= '0;
      scan_idx      <= '0;
      p_valid       <= 1'b0;
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_wr_en) frames_in_use <= cfg_wr_data;
      p_valid       <= cmd.issue;
      result_strobe <= em_valid;

      if (cmd.load) begin
        scan_idx   <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.issue) scan_idx <= scan_idx + IDX_W'(1);

      // Search over the frame that the read stage holds.
      if (p_valid) begin
        if (!hit_found && frame_valid[p_idx] && (rd_tag == id_reg)) hit_found <= 1'b1;
        if (!free_found && !frame_valid[p_idx]) free_found <= 1'b1;
      end

      if (flush_hit) frame_dirty[p_idx] <= 1'b0;

      // Directory update at the end of the item.
      if (fetch_write) begin
        stamp_counter <= stamp_next;
        if (!hit_found) begin
          frame_valid[tgt_idx] <= 1'b1;
          frame_dirty[tgt_idx] <= 1'b0;
        end
      end
      if (cmd.update && (op_reg == lwbfd_pkg::OP_MARK) && hit_found) begin
        frame_dirty[hit_idx] <= 1'b1;
      end
    end
  end

  // Payload registers: item capture, read stage and search indices.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg <= op;
      id_reg <= blk_addr;
    end
    p_idx <= scan_idx;
    if (p_valid) begin
      if (!hit_found && frame_valid[p_idx] && (rd_tag == id_reg)) hit_idx <= p_idx;
      if (!free_found && !frame_valid[p_idx]) free_idx <= p_idx;
      // Lowest stamp wins; ties keep the lower index.
      if ((p_idx == '0) || (rd_stamp < vic_stamp)) begin
        vic_idx   <= p_idx;
        vic_stamp <= rd_stamp;
        vic_tag   <= rd_tag;
      end
    end
  end

  // Tag and stamp memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (fetch_write) begin
      stamp_mem[tgt_idx] <= stamp_next;
      if (!hit_found) tag_mem[tgt_idx] <= id_reg;
    end
    rd_tag   <= tag_mem[scan_idx];
    rd_stamp <= stamp_mem[scan_idx];
  end

  // Result register.
  always_ff @(posedge clk) begin
    kind        <= em_kind;
    frame       <= lwbfd_pkg::FRAME_W'(em_idx);
    writeback   <= em_wb;
    wb_blk_addr <= em_wb_id;
    last        <= em_last;
  end

endmodule

`default_nettype wire

### hw/rtl/lru_write_back_frame_directory_top.sv
// Top level of the LRU write-back frame directory.
// Instantiates lwbfd_ctrl and lwbfd_datapath; depends on lwbfd_pkg.
//
// Usage:
//   An item (op, blk_addr) is accepted at a clock edge with start high and
//   busy low. Fetch and mark give one result; flush gives one write-back
//   result per dirty valid frame in index order and then a done result.
//   Each result is shown for one cycle with result_strobe high; last marks
//   the final result of an item. The receiver cannot stall the block.
//   Every item scans the frames in use one per cycle through the registered
//   read port of the tag and stamp memories, then drains the read stage and
//   updates the directory; busy stays high from the scan to the update.
//   The final result is shown in the first cycle after busy falls, and the
//   next item can be accepted in that same cycle. Flush write-back results
//   come out during the scan and the drain, at most one per cycle.
//   frames_in_use is written through cfg_wr_en / cfg_wr_data; the user must
//   write it only while idle, the block itself does not enforce this.
//   Reset clears all valid and dirty flags, the stamp counter, and sets
//   frames_in_use to sixteen; no clearing pass is needed.
`default_nettype none

module lru_write_back_frame_directory_top #(
  parameter int FRAME_COUNT = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lwbfd_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lwbfd_pkg::OP_W-1:0]      op,
  input  wire logic [lwbfd_pkg::BLOCK_W-1:0]   blk_addr,
  output logic                                 result_strobe,
  output logic [lwbfd_pkg::KIND_W-1:0]         kind,
  output logic [lwbfd_pkg::FRAME_W-1:0]        frame,
  output logic                                 writeback,
  output logic [lwbfd_pkg::BLOCK_W-1:0]        wb_blk_addr,
  output logic                                 last
);

  lwbfd_pkg::ctrl_cmd_t  cmd;
  lwbfd_pkg::dp_status_t status;

  // Sequencer.
  lwbfd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Directory storage and search.
  lwbfd_datapath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .op            (op),
    .blk_addr      (blk_addr),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .kind          (kind),
    .frame         (frame),
    .writeback     (writeback),
    .wb_blk_addr   (wb_blk_addr),
    .last          (last)
  );

endmodule

`default_nettype wire

### hw/rtl/lwbfd_checker.sv
// Port-level checker of the frame directory, bound to the top level.
// Depends on lwbfd_pkg for the result kind codes.
`default_nettype none

module lwbfd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            result_strobe,
  input wire logic [lwbfd_pkg::KIND_W-1:0]    kind,
  input wire logic                            writeback,
  input wire logic [lwbfd_pkg::BLOCK_W-1:0]   wb_blk_addr
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Every result follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result shown without preceding work");

  // Only evictions and flush write-backs request a write-back.
  a_wb_kind: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && writeback) |->
      (kind == lwbfd_pkg::KIND_EVICT || kind == lwbfd_pkg::KIND_FLUSH_WB))
    else $error("write-back on a result kind that cannot carry one");

  // A result without write-back carries a zero block address.
  a_wb_id_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !writeback) |-> (wb_blk_addr == '0))
    else $error("write-back block address not zero");

endmodule

bind lru_write_back_frame_directory_top lwbfd_checker u_lwbfd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .kind          (kind),
  .writeback     (writeback),
  .wb_blk_addr   (wb_blk_addr)
);

`default_nettype wire

### tb/tb_lru_write_back_frame_directory_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_write_back_frame_directory_top.
// Holds a scoreboard class that predicts directory results; depends on lwbfd_pkg and the RTL.

module tb_lru_write_back_frame_directory_top;

  localparam int FRAME_COUNT   = 16;
  localparam int POOL_SIZE     = 24;
  localparam int PHASE_ITEMS   = 30;
  localparam int PHASE_COUNT   = 8;
  localparam int SETTLE_CYCLES = FRAME_COUNT + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_CAP     = 40;

  // The block ignores this opcode.
  localparam logic [lwbfd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // One result of the directory, as seen on the result ports.
  typedef struct packed {
    logic [lwbfd_pkg::KIND_W-1:0]  kind;
    logic [lwbfd_pkg::FRAME_W-1:0] frame;
    logic                          writeback;
    logic [lwbfd_pkg::BLOCK_W-1:0] wb_blk_addr;
    logic                          last;
  } dir_result_t;

  // Mirror of the frame directory and the queue of results it still owes.
  class frame_dir_scoreboard;
    bit                            frame_valid [FRAME_COUNT];
    bit                            frame_dirty [FRAME_COUNT];
    logic [lwbfd_pkg::BLOCK_W-1:0] frame_tag   [FRAME_COUNT];
    logic [lwbfd_pkg::STAMP_W-1:0] frame_stamp [FRAME_COUNT];
    logic [lwbfd_pkg::STAMP_W-1:0] stamp_counter;
    logic [lwbfd_pkg::CFG_W-1:0]   frames_cfg;
    dir_result_t                   pending_results [$];
    int mismatches;
    int items_seen;
    int results_seen;
    int flush_count;
    int hit_count;
    int dirty_evictions;

    function new();
      for (int i = 0; i < FRAME_COUNT; i++) begin
        frame_valid[i] = 1'b0;
        frame_dirty[i] = 1'b0;
        frame_tag[i]   = '0;
        frame_stamp[i] = '0;
      end
      stamp_counter   = '0;
      frames_cfg      = lwbfd_pkg::FRAMES_IN_USE_RESET;
      mismatches      = 0;
      items_seen      = 0;
      results_seen    = 0;
      flush_count     = 0;
      hit_count       = 0;
      dirty_evictions = 0;
    endfunction

    function void set_frames_in_use(logic [lwbfd_pkg::CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    // Zero acts as one frame, and values above the built size are clamped.
    function int frames_active();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > FRAME_COUNT) return FRAME_COUNT;
      return int'(frames_cfg);
    endfunction

    function int find_block(int n, logic [lwbfd_pkg::BLOCK_W-1:0] id);
      for (int i = 0; i < n; i++)
        if (frame_valid[i] && frame_tag[i] == id) return i;
      return -1;
    endfunction

    function void install_block(int idx, logic [lwbfd_pkg::BLOCK_W-1:0] id);
      frame_valid[idx] = 1'b1;
      frame_dirty[idx] = 1'b0;
      frame_tag[idx]   = id;
      frame_stamp[idx] = stamp_counter;
    endfunction

    function void queue_result(logic [lwbfd_pkg::KIND_W-1:0] k, int idx, bit wb,
                               logic [lwbfd_pkg::BLOCK_W-1:0] tag, bit fin);
      dir_result_t r;
      r.kind        = k;
      r.frame       = idx[lwbfd_pkg::FRAME_W-1:0];
      r.writeback   = wb;
      r.wb_blk_addr = wb ? tag : '0;
      r.last        = fin;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted item to the mirror and queue the results it causes.
    function void predict_access(logic [lwbfd_pkg::OP_W-1:0] item_op,
                                 logic [lwbfd_pkg::BLOCK_W-1:0] id);
      int n;
      int idx;
      logic [lwbfd_pkg::STAMP_W-1:0] best;
      n = frames_active();
      items_seen++;
      case (item_op)
        lwbfd_pkg::OP_FETCH: begin
          stamp_counter++;
          idx = find_block(n, id);
          if (idx >= 0) begin
            frame_stamp[idx] = stamp_counter;
            hit_count++;
            queue_result(lwbfd_pkg::KIND_HIT, idx, 1'b0, '0, 1'b1);
            return;
          end
          for (int i = 0; i < n; i++) begin
            if (!frame_valid[i]) begin
              install_block(i, id);
              queue_result(lwbfd_pkg::KIND_FILL, i, 1'b0, '0, 1'b1);
              return;
            end
          end
          // No free frame: the oldest stamp loses, lowest index on a tie.
          idx  = 0;
          best = frame_stamp[0];
          for (int i = 1; i < n; i++) begin
            if (frame_stamp[i] < best) begin
              best = frame_stamp[i];
              idx  = i;
            end
          end
          if (frame_dirty[idx]) dirty_evictions++;
          queue_result(lwbfd_pkg::KIND_EVICT, idx, frame_dirty[idx], frame_tag[idx], 1'b1);
          install_block(idx, id);
        end
        lwbfd_pkg::OP_MARK: begin
          idx = find_block(n, id);
          if (idx >= 0) begin
            frame_dirty[idx] = 1'b1;
            queue_result(lwbfd_pkg::KIND_MARKED, idx, 1'b0, '0, 1'b1);
          end else begin
            queue_result(lwbfd_pkg::KIND_MARK_MISS, 0, 1'b0, '0, 1'b1);
          end
        end
        lwbfd_pkg::OP_FLUSH: begin
          flush_count++;
          for (int i = 0; i < n; i++) begin
            if (frame_valid[i] && frame_dirty[i]) begin
              queue_result(lwbfd_pkg::KIND_FLUSH_WB, i, 1'b1, frame_tag[i], 1'b0);
              frame_dirty[i] = 1'b0;
            end
          end
          queue_result(lwbfd_pkg::KIND_FLUSH_DONE, 0, 1'b0, '0, 1'b1);
        end
        default: begin
          // The unused opcode changes nothing and gives no result.
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compare one observed result with the oldest expected one.
    task check_result(logic [lwbfd_pkg::KIND_W-1:0] got_kind,
                      logic [lwbfd_pkg::FRAME_W-1:0] got_frame,
                      logic got_wb, logic [lwbfd_pkg::BLOCK_W-1:0] got_wb_id,
                      logic got_last);
      dir_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected, kind %0d frame %0d",
                                  got_kind, got_frame));
        return;
      end
      want = pending_results.pop_front();
      if (got_kind !== want.kind)
        report_mismatch($sformatf("kind %0h, expected %0h", got_kind, want.kind));
      if (got_frame !== want.frame)
        report_mismatch($sformatf("frame %0h, expected %0h", got_frame, want.frame));
      if (got_wb !== want.writeback)
        report_mismatch($sformatf("writeback %0h, expected %0h", got_wb, want.writeback));
      if (got_wb_id !== want.wb_blk_addr)
        report_mismatch($sformatf("wb_blk_addr %0h, expected %0h",
                                  got_wb_id, want.wb_blk_addr));
      if (got_last !== want.last)
        report_mismatch($sformatf("last %0h, expected %0h", got_last, want.last));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [lwbfd_pkg::CFG_W-1:0]   cfg_wr_data;
  logic                          start;
  logic                          busy;
  logic [lwbfd_pkg::OP_W-1:0]    op;
  logic [lwbfd_pkg::BLOCK_W-1:0] blk_addr;
  logic                          result_strobe;
  logic [lwbfd_pkg::KIND_W-1:0]  kind;
  logic [lwbfd_pkg::FRAME_W-1:0] frame;
  logic                          writeback;
  logic [lwbfd_pkg::BLOCK_W-1:0] wb_blk_addr;
  logic                          last;

  frame_dir_scoreboard           sb;
  logic [lwbfd_pkg::BLOCK_W-1:0] id_pool  [POOL_SIZE];
  logic [lwbfd_pkg::CFG_W-1:0]   cfg_plan [PHASE_COUNT];
  bit                            idle_enabled;
  int                            settings_used;
  int unsigned                   cycle_count = 0;

  lru_write_back_frame_directory_top #(
    .FRAME_COUNT(FRAME_COUNT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .blk_addr     (blk_addr),
    .result_strobe(result_strobe),
    .kind         (kind),
    .frame        (frame),
    .writeback    (writeback),
    .wb_blk_addr  (wb_blk_addr),
    .last         (last)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results and record accepted items, both on pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_result(kind, frame, writeback, wb_blk_addr, last);
      if (start && !busy) sb.predict_access(op, blk_addr);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_lru_write_back_frame_directory_top failed");
      $finish;
    end
  end

  // Random idle bursts between items, with long stretches of none.
  function automatic int pick_gap();
    if (!idle_enabled) return 0;
    if ($urandom_range(99) < 30) return $urandom_range(9, 1);
    return 0;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [lwbfd_pkg::OP_W-1:0] item_op,
                           input logic [lwbfd_pkg::BLOCK_W-1:0] item_id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= item_op;
    blk_addr <= item_id;
    do @(posedge clk); while (busy);
  endtask

  // Wait until every expected result is in and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_frames_in_use(input logic [lwbfd_pkg::CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_frames_in_use(value);
    settings_used++;
  endtask

  // Mostly fetches and marks over a small block pool so hits and evictions
  // are common, with some random blocks, flushes and unused opcodes mixed in.
  task automatic random_phase(input int count);
    int r;
    logic [lwbfd_pkg::BLOCK_W-1:0] pooled;
    for (int k = 0; k < count; k++) begin
      r      = $urandom_range(99);
      pooled = id_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 55) send_item(lwbfd_pkg::OP_FETCH, pooled);
      else if (r < 77) send_item(lwbfd_pkg::OP_MARK, pooled);
      else if (r < 84) send_item(lwbfd_pkg::OP_FETCH, $urandom);
      else if (r < 87) send_item(lwbfd_pkg::OP_MARK, $urandom);
      else if (r < 95) send_item(lwbfd_pkg::OP_FLUSH, $urandom);
      else send_item(OP_UNUSED, $urandom);
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    start         = 1'b0;
    op            = lwbfd_pkg::OP_FETCH;
    blk_addr      = '0;
    idle_enabled  = 1'b1;
    settings_used = 1;
    sb            = new();

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    // Frame counts per phase: below, at and above the legal range; the last
    // phase restores all sixteen frames and runs without idling.
    cfg_plan = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd9, 5'd17, 5'd2, 5'd16};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: mark miss on an empty pool, fills, a hit, marks, flushes
    // with and without dirty frames, the unused opcode, then a dirty eviction.
    send_item(lwbfd_pkg::OP_MARK, '0);
    send_item(lwbfd_pkg::OP_FETCH, '0);
    send_item(lwbfd_pkg::OP_FETCH, '1);
    send_item(lwbfd_pkg::OP_FETCH, '0);
    send_item(lwbfd_pkg::OP_MARK, '1);
    send_item(lwbfd_pkg::OP_MARK, '0);
    send_item(lwbfd_pkg::OP_FLUSH, 32'hA5A5_5A5A);
    send_item(lwbfd_pkg::OP_FLUSH, '0);
    send_item(OP_UNUSED, 32'h5A5A_A5A5);
    for (int i = 1; i <= 14; i++) send_item(lwbfd_pkg::OP_FETCH, i);
    send_item(lwbfd_pkg::OP_MARK, '1);
    send_item(lwbfd_pkg::OP_FETCH, 32'h1234_5678);

    // Random phases, each under a new frame count.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      if (ph == PHASE_COUNT - 1) idle_enabled = 1'b0;
      write_frames_in_use(cfg_plan[ph]);
      random_phase(PHASE_ITEMS);
    end
    settle();

    $display("Covered %0d items (%0d flushes, %0d hits, %0d dirty evictions) under %0d settings,",
             sb.items_seen, sb.flush_count, sb.hit_count, sb.dirty_evictions, settings_used);
    $display("with %0d results checked and %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_lru_write_back_frame_directory_top passed");
    end else begin
      $display("tb_lru_write_back_frame_directory_top failed");
    end
    $finish;
  end

endmodule
